[hw/rtl/b64e_pkg.sv]
// Base64 encoder package: phase codes, queue entry type, alphabet lookup.
// No dependencies; imported by the front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // Position within the three-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Up to four characters produced by one input byte
  typedef struct packed {
    logic [3:0][7:0] chars;     // chars[0] goes out first
    logic [1:0]      last_idx;  // index of the final valid character
    logic            last;      // entry ends the message
  } entry_t;

  // Map a sextet to its ASCII character
  function automatic logic [7:0] b64e_char(input logic [5:0] v);
    logic [7:0] wide;
    wide = {2'b00, v};
    if (v < 6'd26) begin
      return wide + 8'h41;
    end else if (v < 6'd52) begin
      return wide - 8'd26 + 8'h61;
    end else if (v < 6'd62) begin
      return wide - 8'd52 + 8'h30;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/b64e_in_if.sv]
// Input channel of the Base64 encoder: one raw byte and an end-of-message flag.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/b64e_out_if.sv]
// Output channel of the Base64 encoder: one ASCII character and a final flag.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/b64e_front.sv]
// Front end: accepts raw bytes, tracks the group phase and leftover bits,
// and builds the character entry for each byte. Uses b64e_pkg, b64e_in_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  b64e_in_if.sink raw,
  input  logic   q_full,
  output logic   push,
  output entry_t entry
);

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;
  logic [7:0] b;

  assign raw.ready = !q_full;
  assign push      = raw.valid && !q_full;
  assign b         = raw.data_byte;

  // Build the entry and the next phase
  always_comb begin
    phase_next     = phase;
    leftover_next  = leftover;
    entry.chars    = {4{PAD_CHAR}};
    entry.last     = raw.last_byte;
    entry.last_idx = 2'd0;
    unique case (phase)
      PH_1: begin
        entry.chars[0] = b64e_char({leftover[1:0], b[7:4]});
        if (raw.last_byte) begin
          entry.chars[1] = b64e_char({b[3:0], 2'b00});
          entry.last_idx = 2'd2;
        end else begin
          leftover_next = b[3:0];
          phase_next    = PH_2;
        end
      end
      PH_2: begin
        entry.chars[0] = b64e_char({leftover, b[7:6]});
        entry.chars[1] = b64e_char(b[5:0]);
        entry.last_idx = 2'd1;
        leftover_next  = 4'd0;
        phase_next     = PH_0;
      end
      default: begin
        entry.chars[0] = b64e_char(b[7:2]);
        if (raw.last_byte) begin
          entry.chars[1] = b64e_char({b[1:0], 4'b0000});
          entry.last_idx = 2'd3;
        end else begin
          leftover_next = {2'b00, b[1:0]};
          phase_next    = PH_1;
        end
      end
    endcase
    if (raw.last_byte) begin
      phase_next    = PH_0;
      leftover_next = 4'd0;
    end
  end

  // Advance the group state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

`ifndef SYNTHESIS
  a_last_resets_phase: assert property (@(posedge clk) disable iff (rst)
    push && raw.last_byte |=> phase == PH_0 && leftover == 4'd0)
    else $error("phase not cleared after last byte");
  a_leftover_width: assert property (@(posedge clk) disable iff (rst)
    phase == PH_1 |-> leftover[3:2] == 2'b00)
    else $error("leftover holds more than two bits after first byte");
`endif

endmodule

`default_nettype wire

[hw/rtl/b64e_queue.sv]
// Short entry queue between the front and back ends.
// Uses b64e_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy exceeds depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[hw/rtl/b64e_back.sv]
// Back end: walks the head entry into the output register, one character
// per cycle while the output is not stalled. Uses b64e_pkg and b64e_out_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  b64e_out_if.source enc
);

  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] idx;
  logic       advance;
  logic       at_end;

  assign advance = head_valid && (!out_valid || enc.ready);
  assign at_end  = idx == head.last_idx;
  assign pop     = advance && at_end;

  assign enc.valid    = out_valid;
  assign enc.out_char = out_char;
  assign enc.out_last = out_last;

  // Load the output register and step through the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (enc.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= head.chars[idx];
      out_last <= head.last && at_end;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("character index beyond entry");
  a_idx_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 2'd0)
    else $error("character index left mid-entry with queue empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/base64_stream_encoder.sv]
// Base64 stream encoder top level: front end, entry queue, back end.
// Uses b64e_pkg, b64e_in_if, b64e_out_if, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   raw : one message byte per transaction (data_byte), last_byte set on the
//         final byte of a message. Every message has at least one byte.
//   enc : one ASCII character per transaction (out_char), out_last set on
//         the final character, after '=' padding to a multiple of four.
// Path: a byte accepted into an empty encoder is stored in a queue slot, then its
//   first character is loaded into the output register; queued entries and output stalls delay it.
// Throughput: the back end sends one character per cycle while enc.ready
//   allows; a byte yields one or two characters mid-message (about 1.33 on
//   average), up to four on the last byte. The front end accepts a
//   byte every cycle while the QUEUE_DEPTH-entry queue has room.
// Reset: synchronous; clears the group phase, the queue and the output
//   register. No clearing pass is needed.
// Stall: when enc.ready is low the output character holds, the queue fills,
//   and raw.ready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input logic         clk,
  input logic         rst,
  b64e_in_if.sink     raw,
  b64e_out_if.source  enc
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   head_valid;

  b64e_front u_front (
    .clk   (clk),
    .rst   (rst),
    .raw   (raw),
    .q_full(q_full),
    .push  (push),
    .entry (push_entry)
  );

  b64e_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .enc       (enc)
  );

endmodule

`default_nettype wire
